// ===== sv/rcrm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcrm_pkg
// Shared types, constants and the square root digit step of the rounded
// corner row mask.
// ----------------------------------------------------------------------------
package rcrm_pkg;

	localparam int ROW_W        = 8;
	localparam int RADIUS_W     = 16;
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int RADICAND_W   = 2 * RADIUS_W;
	localparam int ROOT_W       = RADIUS_W;
	localparam int REM_W        = ROOT_W + 4;
	localparam int SQRT_STEPS   = 2;
	localparam int SQRT_STAGES  = ROOT_W / SQRT_STEPS;
	localparam int TUSER_W      = 3;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AA     = 2'd3;

	// Bit positions inside tuser.
	localparam int TU_ROW_VALID  = 0;
	localparam int TU_FILL_VALID = 1;
	localparam int TU_EDGE_VALID = 2;

	typedef struct packed {
		logic                row_ok;
		logic [ROW_W-1:0]    row;
		logic [RADIUS_W-1:0] radius;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_state_t;

	// One restoring digit step of the integer square root: brings in the next
	// two radicand bits and decides one root bit.
	function automatic sq_state_t sqrt_step(sq_state_t cur, logic [1:0] pair);
		logic [REM_W-1:0] rem_t;
		logic [REM_W-1:0] trial;
		sq_state_t        nxt;
		rem_t = {cur.rem[REM_W-3:0], pair};
		trial = REM_W'({cur.root, 2'b01});
		if (rem_t >= trial) begin
			nxt.rem  = rem_t - trial;
			nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = rem_t;
			nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

// ===== sv/rounded_corner_row_mask.sv =====
// ----------------------------------------------------------------------------
// rounded_corner_row_mask
// Per-row cleared run, edge positions and antialias alpha of a rounded corner.
// ----------------------------------------------------------------------------
// A request passes registers s1 to s3, the square root stages, s4 and s5.
// Throughput: one request per cycle while m_axis_tready holds; the eight-stage
// square root pipeline (two root bits per stage) sets the depth, not the rate.
// Reset: arst_n clears all valid bits and loads the registers with radius 0,
// width 1, height 1 and antialias enabled.
module rounded_corner_row_mask
	import rcrm_pkg::*;
#(
	parameter int COORD_BITS       = 12,
	parameter int RADIUS_FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [7:0] row_index
	input  logic [ROW_W-1:0]     s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// fill_width, right_fill_start, right_edge_x, top_row_y, bottom_row_y,
	// edge_alpha, zero pad
	output logic [((3*ROW_W + 3*(COORD_BITS+1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// [0] row_valid, [1] fill_valid, [2] edge_valid
	output logic [TUSER_W-1:0]   m_axis_tuser
);

	localparam int F         = RADIUS_FRAC_BITS;
	localparam int PW        = COORD_BITS + 1;
	localparam int DATA_BITS = 3 * ROW_W + 3 * PW;
	localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;
	localparam int IW        = ROW_W + F;
	localparam int CW        = ((IW > RADIUS_W) ? IW : RADIUS_W) + 2;
	localparam int HALF      = 1 << (F - 1);
	localparam int ONE       = 1 << F;
	localparam int AW        = F + 9;

	// Configuration registers.
	logic [RADIUS_W-1:0]   radius_q;
	logic [COORD_BITS-1:0] width_q;
	logic [COORD_BITS-1:0] height_q;
	logic                  aa_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			width_q  <= COORD_BITS'(1);
			height_q <= COORD_BITS'(1);
			aa_q     <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data[RADIUS_W-1:0];
				REG_WIDTH:  width_q  <= cfg_data[COORD_BITS-1:0];
				REG_HEIGHT: height_q <= cfg_data[COORD_BITS-1:0];
				REG_AA:     aa_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stall chain.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic sq_in_ready, sq_out_valid;

	assign en_s5 = !v_s5 || m_axis_tready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || sq_in_ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_axis_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= sq_out_valid;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Stage 1: row check and |r - (i + 1/2)|. A row is inside the corner when
	// i * 2^F is below r, which is the same as i < ceil(r).
	logic [CW-1:0]       row_sh_c, rad_ext_c, d_c, dabs_c;
	logic                rok_c;
	side_t               side_s1;
	logic [RADIUS_W-1:0] dabs_s1;

	always_comb begin
		row_sh_c  = CW'(s_axis_tdata) << F;
		rad_ext_c = CW'(radius_q);
		rok_c     = row_sh_c < rad_ext_c;
		d_c       = rad_ext_c - row_sh_c - CW'(HALF);
		dabs_c    = d_c[CW-1] ? (~d_c + CW'(1)) : d_c;
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_axis_tvalid) begin
			side_s1.row_ok <= rok_c;
			side_s1.row    <= s_axis_tdata;
			side_s1.radius <= radius_q;
			dabs_s1        <= dabs_c[RADIUS_W-1:0];
		end
	end

	// Stage 2: r*r and d*d.
	side_t                 side_s2;
	logic [RADICAND_W-1:0] rr_s2, dd_s2;

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			side_s2 <= side_s1;
			dd_s2   <= RADICAND_W'(dabs_s1) * RADICAND_W'(dabs_s1);
			rr_s2   <= RADICAND_W'(side_s1.radius) * RADICAND_W'(side_s1.radius);
		end
	end

	// Stage 3: radicand, clamped at zero.
	side_t                 side_s3;
	logic [RADICAND_W-1:0] rdc_s3;

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			side_s3 <= side_s2;
			rdc_s3  <= (rr_s2 > dd_s2) ? (rr_s2 - dd_s2) : '0;
		end
	end

	logic [ROOT_W-1:0] sq_root;
	side_t             sq_side;

	rcrm_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (sq_in_ready),
		.radicand  (rdc_s3),
		.in_side   (side_s3),
		.out_valid (sq_out_valid),
		.out_ready (en_s4),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	// Stage 4: arc crossing, cleared run and coverage of the edge pixel.
	logic [RADIUS_W-1:0] xb_c, full_c;
	logic [ROW_W-1:0]    fw_c;
	logic [F:0]          cov_c;
	logic                rok_s4, nz_s4;
	logic [ROW_W-1:0]    row_s4, fw_s4;
	logic [F:0]          cov_s4;

	always_comb begin
		xb_c   = (sq_root <= sq_side.radius) ? (sq_side.radius - sq_root) : '0;
		full_c = xb_c >> F;
		fw_c   = (full_c > RADIUS_W'(255)) ? 8'hFF : full_c[ROW_W-1:0];
		// Coverage is one minus the fractional part of the crossing.
		cov_c  = (F + 1)'(ONE) - {1'b0, xb_c[F-1:0]};
	end

	always_ff @(posedge clk) begin
		if (en_s4 && sq_out_valid) begin
			rok_s4 <= sq_side.row_ok;
			row_s4 <= sq_side.row;
			nz_s4  <= full_c != '0;
			fw_s4  <= fw_c;
			cov_s4 <= cov_c;
		end
	end

	// Stage 5: alpha, positions and the output register.
	logic [AW-1:0]      prod_c;
	logic [ROW_W-1:0]   alpha_c;
	logic [PW-1:0]      rfs_c, rex_c, bot_c;
	logic [TDATA_W-1:0] tdata_s5;
	logic [TUSER_W-1:0] tuser_s5;
	logic [TDATA_W-1:0] tdata_c;
	logic [TUSER_W-1:0] tuser_c;

	always_comb begin
		prod_c  = AW'(cov_s4) * AW'(255) + AW'(HALF);
		alpha_c = prod_c[F + ROW_W - 1:F];
		rfs_c   = PW'(width_q) - PW'(fw_s4);
		rex_c   = rfs_c - PW'(1);
		bot_c   = PW'(height_q) - PW'(1) - PW'(row_s4);
		tdata_c = '0;
		tuser_c = '0;
		if (rok_s4) begin
			tdata_c = TDATA_W'({(aa_q ? alpha_c : 8'h00), bot_c, row_s4, rex_c, rfs_c, fw_s4});
			tuser_c[TU_ROW_VALID]  = 1'b1;
			tuser_c[TU_FILL_VALID] = nz_s4;
			tuser_c[TU_EDGE_VALID] = aa_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			tdata_s5 <= tdata_c;
			tuser_s5 <= tuser_c;
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = tdata_s5;
	assign m_axis_tuser  = tuser_s5;

endmodule

// ===== sv/rcrm_isqrt.sv =====
// ----------------------------------------------------------------------------
// rcrm_isqrt
// Pipelined floor integer square root of a 32-bit radicand, two root bits
// per stage, with per-stage valid bits and a stall chain.
// ----------------------------------------------------------------------------
module rcrm_isqrt
	import rcrm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [RADICAND_W-1:0] radicand,
	input  side_t                 in_side,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ROOT_W-1:0]     root,
	output side_t                 out_side
);

	logic [SQRT_STAGES-1:0] vld_s;
	logic [SQRT_STAGES-1:0] en;
	logic [RADICAND_W-1:0]  rad_s  [SQRT_STAGES];
	sq_state_t              st_s   [SQRT_STAGES];
	side_t                  side_s [SQRT_STAGES];

	// A stage takes a new request when it is empty or its content moves on.
	always_comb begin
		en[SQRT_STAGES-1] = !vld_s[SQRT_STAGES-1] || out_ready;
		for (int k = SQRT_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		logic                  v_in;
		logic [RADICAND_W-1:0] rad_in;
		sq_state_t             st_in;
		side_t                 side_in;
		logic [RADICAND_W-1:0] rad_nxt;
		sq_state_t             st_nxt;

		if (g == 0) begin : g_first
			assign v_in    = in_valid;
			assign rad_in  = radicand;
			assign st_in   = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = vld_s[g-1];
			assign rad_in  = rad_s[g-1];
			assign st_in   = st_s[g-1];
			assign side_in = side_s[g-1];
		end

		always_comb begin
			st_nxt  = st_in;
			rad_nxt = rad_in;
			for (int j = 0; j < SQRT_STEPS; j++) begin
				st_nxt  = sqrt_step(st_nxt, rad_nxt[RADICAND_W-1 -: 2]);
				rad_nxt = rad_nxt << 2;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en[g]) begin
				vld_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en[g] && v_in) begin
				rad_s[g]  <= rad_nxt;
				st_s[g]   <= st_nxt;
				side_s[g] <= side_in;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[SQRT_STAGES-1];
	assign root      = st_s[SQRT_STAGES-1].root;
	assign out_side  = side_s[SQRT_STAGES-1];

endmodule

// ===== sv/rcrm_checker.sv =====
// ----------------------------------------------------------------------------
// rcrm_checker
// Port-level checks of the rounded corner row mask, bound to the top level.
// ----------------------------------------------------------------------------
module rcrm_checker
	import rcrm_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [((3*ROW_W + 3*(COORD_BITS+1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
	input logic [TUSER_W-1:0]   m_axis_tuser
);

	localparam int PW     = COORD_BITS + 1;
	localparam int RFS_LO = ROW_W;
	localparam int REX_LO = ROW_W + PW;

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// A row outside the corner carries nothing else.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[TU_ROW_VALID] |->
		m_axis_tdata == '0 && m_axis_tuser == '0)
		else $error("invalid row with nonzero fields");

	// The fill flag follows the run length.
	a_fill_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[TU_ROW_VALID] |->
		m_axis_tuser[TU_FILL_VALID] == (m_axis_tdata[ROW_W-1:0] != '0))
		else $error("fill_valid disagrees with fill_width");

	// The edge pixel sits just left of the right cleared run.
	a_edge_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[TU_ROW_VALID] |->
		m_axis_tdata[REX_LO +: PW] == PW'(m_axis_tdata[RFS_LO +: PW] - PW'(1)))
		else $error("right_edge_x is not right_fill_start minus one");

endmodule

bind rounded_corner_row_mask rcrm_checker #(
	.COORD_BITS (COORD_BITS)
) u_rcrm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== test/tb_rounded_corner_row_mask.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rounded_corner_row_mask
// Self-checking bench for the rounded corner row mask. A short directed list
// covers reset values, radius and frame size extremes, antialias on and off
// and the last valid row. Random register settings with mostly valid rows
// follow. Every result is compared field by field against an in-bench
// computation of the corner arc, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_rounded_corner_row_mask;
	import rcrm_pkg::*;

	localparam int COORD_BITS  = 12;
	localparam int FRAC_BITS   = 8;
	localparam int POS_W       = COORD_BITS + 1;
	localparam int TDATA_W     = ((3*ROW_W + 3*POS_W + 7) / 8) * 8;
	localparam int DRAIN_WAIT  = 20;
	localparam int IDLE_LIMIT  = 4000;
	localparam int PHASES      = 10;
	localparam int PHASE_ROWS  = 60;

	// Field offsets inside m_axis_tdata, lowest field first.
	localparam int OFS_FILL   = 0;
	localparam int OFS_RSTART = OFS_FILL + ROW_W;
	localparam int OFS_REDGE  = OFS_RSTART + POS_W;
	localparam int OFS_TOP    = OFS_REDGE + POS_W;
	localparam int OFS_BOTTOM = OFS_TOP + ROW_W;
	localparam int OFS_ALPHA  = OFS_BOTTOM + POS_W;

	typedef struct packed {
		logic             row_valid;
		logic             fill_valid;
		logic [ROW_W-1:0] fill_width;
		logic [POS_W-1:0] right_fill_start;
		logic [POS_W-1:0] right_edge_x;
		logic [ROW_W-1:0] top_row_y;
		logic [POS_W-1:0] bottom_row_y;
		logic             edge_valid;
		logic [ROW_W-1:0] edge_alpha;
	} row_mask_t;

	typedef struct packed {
		logic                 is_write;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		logic [ROW_W-1:0]     row;
		logic                 typed;
		row_mask_t            mask;
	} step_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [ROW_W-1:0]     s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [TDATA_W-1:0]   m_axis_tdata;
	logic [TUSER_W-1:0]   m_axis_tuser;

	rounded_corner_row_mask #(
		.COORD_BITS       (COORD_BITS),
		.RADIUS_FRAC_BITS (FRAC_BITS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Bench copy of the register file.
	logic [CFG_W-1:0]      cur_radius;
	logic [COORD_BITS-1:0] cur_width;
	logic [COORD_BITS-1:0] cur_height;
	logic                  cur_aa;

	row_mask_t   pending_masks[$];
	step_t       plan[0:39];
	int          plan_len;
	int unsigned mismatch_count;
	int unsigned rows_sent;
	int unsigned rows_checked;
	int unsigned valid_rows;
	int unsigned partial_edges;
	int unsigned settings_used;
	int unsigned idle_cycles;
	int unsigned stall_left;
	bit          rx_calm;
	bit          tx_calm;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned res;
		longint unsigned trial;
		res = 0;
		for (int b = 20; b >= 0; b--) begin
			trial = res | (64'd1 << b);
			if (trial * trial <= v)
				res = trial;
		end
		return res;
	endfunction

	// Where the corner arc crosses the row center, and the mask that follows.
	function automatic row_mask_t corner_mask_for_row(input logic [ROW_W-1:0] row);
		longint unsigned one;
		longint unsigned r;
		longint unsigned rows_in_corner;
		longint unsigned center;
		longint unsigned d_abs;
		longint unsigned rad;
		longint unsigned root;
		longint unsigned xb;
		longint unsigned full;
		longint unsigned cov;
		longint unsigned alpha;
		logic [ROW_W-1:0] run;
		row_mask_t        m;
		m = '0;
		one = 64'd1 << FRAC_BITS;
		r = 64'(cur_radius);
		rows_in_corner = (r + one - 1) >> FRAC_BITS;
		if (64'(row) >= rows_in_corner)
			return m;
		center = (64'(row) << FRAC_BITS) + (one >> 1);
		d_abs = (r >= center) ? r - center : center - r;
		rad = (r * r > d_abs * d_abs) ? r * r - d_abs * d_abs : 0;
		root = floor_root(rad);
		xb = (root <= r) ? r - root : 0;
		full = xb >> FRAC_BITS;
		run = (full > 255) ? 8'd255 : full[ROW_W-1:0];
		cov = ((full + 1) << FRAC_BITS) - xb;
		if (cov > one)
			cov = one;
		alpha = (cov * 255 + (one >> 1)) >> FRAC_BITS;
		if (alpha > 255)
			alpha = 255;
		m.row_valid        = 1'b1;
		m.fill_valid       = (full != 0);
		m.fill_width       = run;
		m.right_fill_start = {1'b0, cur_width} - POS_W'(run);
		m.right_edge_x     = {1'b0, cur_width} - POS_W'(1) - POS_W'(run);
		m.top_row_y        = row;
		m.bottom_row_y     = {1'b0, cur_height} - POS_W'(1) - POS_W'(row);
		if (cur_aa) begin
			m.edge_valid = 1'b1;
			m.edge_alpha = alpha[ROW_W-1:0];
		end
		return m;
	endfunction

	function automatic step_t reg_step(input logic [CFG_IDX_W-1:0] idx,
	                                   input logic [CFG_W-1:0] data);
		step_t s;
		s = '0;
		s.is_write = 1'b1;
		s.idx      = idx;
		s.data     = data;
		return s;
	endfunction

	function automatic step_t row_step(input logic [ROW_W-1:0] row, input logic blank);
		step_t s;
		s = '0;
		s.row   = row;
		s.typed = blank;
		return s;
	endfunction

	task automatic plan_add(input step_t s);
		plan[plan_len] = s;
		plan_len++;
	endtask

	function automatic int unsigned pick_gap(input bit calm);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Registers change only with nothing in flight.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		s_axis_tvalid <= 1'b0;
		while (pending_masks.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RADIUS: cur_radius = data;
			REG_WIDTH:  cur_width  = data[COORD_BITS-1:0];
			REG_HEIGHT: cur_height = data[COORD_BITS-1:0];
			REG_AA:     cur_aa     = data[0];
			default: ;
		endcase
	endtask

	task automatic send_row(input logic [ROW_W-1:0] row, input logic typed,
	                        input row_mask_t typed_mask);
		int unsigned gap;
		s_axis_tdata  <= row;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_masks.push_back(typed ? typed_mask : corner_mask_for_row(row));
		rows_sent++;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Output side stalls, with calm stretches that come and go.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= stall_left - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (!rx_calm) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4: stall_left <= $urandom_range(1, 3);
					5:             stall_left <= $urandom_range(10, 40);
					default: ;
				endcase
			end
		end
		if ($urandom_range(0, 299) == 0)
			rx_calm <= ~rx_calm;
	end

	always @(posedge clk) begin
		row_mask_t got;
		row_mask_t want;
		string     bad;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.row_valid        = m_axis_tuser[TU_ROW_VALID];
			got.fill_valid       = m_axis_tuser[TU_FILL_VALID];
			got.edge_valid       = m_axis_tuser[TU_EDGE_VALID];
			got.fill_width       = m_axis_tdata[OFS_FILL +: ROW_W];
			got.right_fill_start = m_axis_tdata[OFS_RSTART +: POS_W];
			got.right_edge_x     = m_axis_tdata[OFS_REDGE +: POS_W];
			got.top_row_y        = m_axis_tdata[OFS_TOP +: ROW_W];
			got.bottom_row_y     = m_axis_tdata[OFS_BOTTOM +: POS_W];
			got.edge_alpha       = m_axis_tdata[OFS_ALPHA +: ROW_W];
			if (pending_masks.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result with no request outstanding, tdata=%h tuser=%b",
					         $realtime, m_axis_tdata, m_axis_tuser);
			end else begin
				want = pending_masks.pop_front();
				rows_checked++;
				if (want.row_valid)
					valid_rows++;
				if (want.edge_valid && want.edge_alpha != 0 && want.edge_alpha != 8'hFF)
					partial_edges++;
				bad = "";
				if (got.row_valid !== want.row_valid)               bad = {bad, " row_valid"};
				if (got.fill_valid !== want.fill_valid)             bad = {bad, " fill_valid"};
				if (got.fill_width !== want.fill_width)             bad = {bad, " fill_width"};
				if (got.right_fill_start !== want.right_fill_start) bad = {bad, " right_fill_start"};
				if (got.right_edge_x !== want.right_edge_x)         bad = {bad, " right_edge_x"};
				if (got.top_row_y !== want.top_row_y)               bad = {bad, " top_row_y"};
				if (got.bottom_row_y !== want.bottom_row_y)         bad = {bad, " bottom_row_y"};
				if (got.edge_valid !== want.edge_valid)             bad = {bad, " edge_valid"};
				if (got.edge_alpha !== want.edge_alpha)             bad = {bad, " edge_alpha"};
				if (bad != "") begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: result %0d wrong in%s", $realtime, rows_checked, bad);
						$display("  expected rv=%b fv=%b fw=%0d rs=%h re=%h top=%0d bot=%h ev=%b a=%0d",
						         want.row_valid, want.fill_valid, want.fill_width,
						         want.right_fill_start, want.right_edge_x, want.top_row_y,
						         want.bottom_row_y, want.edge_valid, want.edge_alpha);
						$display("  actual   rv=%b fv=%b fw=%0d rs=%h re=%h top=%0d bot=%h ev=%b a=%0d",
						         got.row_valid, got.fill_valid, got.fill_width,
						         got.right_fill_start, got.right_edge_x, got.top_row_y,
						         got.bottom_row_y, got.edge_valid, got.edge_alpha);
					end
				end
			end
		end
	end

	// Ends the run if neither side moves for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout after %0d cycles without a transfer, %0d results missing",
			         IDLE_LIMIT, pending_masks.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int unsigned     rows_in_corner;
		logic [ROW_W-1:0] row;
		logic [CFG_W-1:0] radius;
		logic [CFG_W-1:0] width;
		logic [CFG_W-1:0] height;
		logic [CFG_W-1:0] aa;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_RADIUS;
		cfg_data       = '0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b0;
		stall_left     = 0;
		rx_calm        = 1'b0;
		tx_calm        = 1'b0;
		idle_cycles    = 0;
		mismatch_count = 0;
		rows_sent      = 0;
		rows_checked   = 0;
		valid_rows     = 0;
		partial_edges  = 0;
		settings_used  = 1;
		cur_radius     = '0;
		cur_width      = COORD_BITS'(1);
		cur_height     = COORD_BITS'(1);
		cur_aa         = 1'b1;
		plan_len       = 0;

		// Rows typed as blank are outside the corner, so every field is zero.
		plan_add(row_step(8'd0, 1'b1));
		plan_add(row_step(8'd255, 1'b1));
		plan_add(reg_step(REG_RADIUS, 16'h0100));
		plan_add(reg_step(REG_WIDTH, 16'hFFFF));
		plan_add(reg_step(REG_HEIGHT, 16'h0FFF));
		plan_add(row_step(8'd0, 1'b0));
		plan_add(row_step(8'd1, 1'b1));
		plan_add(reg_step(REG_RADIUS, 16'hFFFF));
		plan_add(row_step(8'd0, 1'b0));
		plan_add(row_step(8'd127, 1'b0));
		plan_add(row_step(8'd255, 1'b0));
		plan_add(row_step(8'd128, 1'b0));
		plan_add(reg_step(REG_AA, 16'h0000));
		plan_add(row_step(8'd0, 1'b0));
		plan_add(row_step(8'd200, 1'b0));
		plan_add(reg_step(REG_WIDTH, 16'h0000));
		plan_add(reg_step(REG_HEIGHT, 16'h0000));
		plan_add(row_step(8'd0, 1'b0));
		plan_add(row_step(8'd255, 1'b0));
		plan_add(reg_step(REG_AA, 16'h0001));
		plan_add(reg_step(REG_RADIUS, 16'h0001));
		plan_add(row_step(8'd0, 1'b0));
		plan_add(row_step(8'd1, 1'b1));
		plan_add(reg_step(REG_RADIUS, 16'h8080));
		plan_add(reg_step(REG_WIDTH, 16'h0001));
		plan_add(row_step(8'd128, 1'b0));
		plan_add(row_step(8'd129, 1'b1));
		plan_add(row_step(8'd64, 1'b0));
		plan_add(reg_step(REG_RADIUS, 16'h0180));
		plan_add(row_step(8'd0, 1'b0));
		plan_add(row_step(8'd1, 1'b0));
		plan_add(row_step(8'd2, 1'b1));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < plan_len; n++) begin
			if (plan[n].is_write) begin
				write_reg(plan[n].idx, plan[n].data);
				settings_used++;
			end else begin
				send_row(plan[n].row, plan[n].typed, plan[n].mask);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				radius = 16'hFFFF;
				width  = 16'h0FFF;
				height = 16'h0FFF;
				aa     = 16'h0001;
			end else if (p == 1) begin
				radius = 16'h8000;
				width  = 16'h0000;
				height = 16'hF000;
				aa     = 16'hFFFE;
			end else begin
				case ($urandom_range(0, 4))
					0:       radius = CFG_W'($urandom_range(0, 65535));
					1:       radius = CFG_W'($urandom_range(1, 16'h0800));
					2:       radius = 16'hFFFF;
					3:       radius = CFG_W'($urandom_range(0, 255));
					default: radius = 16'($urandom_range(1, 255)) << FRAC_BITS;
				endcase
				case ($urandom_range(0, 3))
					0:       width = CFG_W'($urandom_range(0, 65535));
					1:       width = 16'h0000;
					2:       width = $urandom_range(0, 1) ? 16'h0001 : 16'h0FFF;
					default: width = CFG_W'($urandom_range(1, 4095));
				endcase
				case ($urandom_range(0, 3))
					0:       height = CFG_W'($urandom_range(0, 65535));
					1:       height = 16'h0000;
					2:       height = $urandom_range(0, 1) ? 16'h0001 : 16'h0FFF;
					default: height = CFG_W'($urandom_range(1, 4095));
				endcase
				aa = CFG_W'($urandom_range(0, 65535));
			end
			write_reg(REG_RADIUS, radius);
			write_reg(REG_WIDTH, width);
			write_reg(REG_HEIGHT, height);
			write_reg(REG_AA, aa);
			settings_used++;
			tx_calm = ($urandom_range(0, 3) == 0);
			rows_in_corner = (int'(cur_radius) + (1 << FRAC_BITS) - 1) >> FRAC_BITS;
			for (int k = 0; k < PHASE_ROWS; k++) begin
				// Most rows fall inside the corner so the arc math gets exercised.
				if (rows_in_corner > 0 && $urandom_range(0, 99) < 85)
					row = ROW_W'($urandom_range(0,
					      (rows_in_corner > 256) ? 255 : rows_in_corner - 1));
				else
					row = ROW_W'($urandom_range(0, 255));
				send_row(row, 1'b0, '0);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_masks.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Checked %0d of %0d rows over %0d register settings.",
		         rows_checked, rows_sent, settings_used);
		$display("%0d rows were inside the corner, %0d had a partially covered edge pixel.",
		         valid_rows, partial_edges);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d results were wrong.", mismatch_count);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== rounded_corner_row_mask.f =====
sv/rcrm_pkg.sv
sv/rcrm_isqrt.sv
sv/rounded_corner_row_mask.sv
sv/rcrm_checker.sv
test/tb_rounded_corner_row_mask.sv
